// ===== rtl/ohlcv_pkg.sv =====
// Shared types and constants for the one-minute OHLCV bar aggregator.
`timescale 1ns / 1ps

package ohlcv_pkg;

    localparam int NUM_SYMBOLS = 32;
    localparam int IDX_W       = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int SYM_W       = 5;
    localparam int PRICE_W     = 32;
    localparam int SIZE_W      = 32;
    localparam int TIME_W      = 32;
    localparam int VOL_W       = 48;
    localparam int BAR_PERIOD  = 60;

    // floor(x / 15) = (x * DIV15_MUL) >> 35, exact for x below 2^30.
    localparam logic [31:0] DIV15_MUL   = 32'h8888_8889;
    localparam int          DIV15_SHIFT = 35;
    localparam int          PROD_W      = (TIME_W - 2) + 32;

    typedef struct packed {
        logic [TIME_W-1:0]  start;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic [VOL_W-1:0]   volume;
    } t_slot;

    typedef struct packed {
        logic             latch;      // capture the accepted beat
        logic             rd_en;      // read the slot table
        logic [IDX_W-1:0] rd_addr;
        logic             trade_upd;  // fold the trade into the slot just read
        logic             tick_eval;  // test the slot just read for a closed bar
        logic             tick_flush; // release the held bar as the last one
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRADE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

endpackage

// ===== rtl/ohlcv_ctrl.sv =====
// Sequencer for trade updates and tick scans of the slot table.
`timescale 1ns / 1ps

module ohlcv_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      i_kind,
    input  logic [ohlcv_pkg::SYM_W-1:0] i_symbol,
    output logic                      busy,
    output ohlcv_pkg::t_cmd           o_cmd
);
    import ohlcv_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             accept;
    logic             sym_ok;

    assign accept = start && (r_state == ST_IDLE);
    assign sym_ok = (32'(i_symbol) < 32'(NUM_SYMBOLS));
    assign busy   = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    n_idx       = '0;
                    if (!i_kind) begin
                        if (sym_ok) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = IDX_W'(i_symbol);
                            n_state       = ST_TRADE;
                        end
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_TRADE: begin
                o_cmd.trade_upd = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_addr   = r_idx;
                o_cmd.tick_eval = (r_idx != '0);
                if (r_idx == IDX_W'(NUM_SYMBOLS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                o_cmd.tick_eval = 1'b1;
                n_state         = ST_FLUSH;
            end
            ST_FLUSH: begin
                o_cmd.tick_flush = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ohlcv_dp.sv =====
// Slot table, bar update arithmetic and result registers.
`timescale 1ns / 1ps

module ohlcv_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ohlcv_pkg::t_cmd               i_cmd,
    input  logic [ohlcv_pkg::PRICE_W-1:0] i_price,
    input  logic [ohlcv_pkg::SIZE_W-1:0]  i_trade_size,
    input  logic [ohlcv_pkg::TIME_W-1:0]  i_time_sec,
    output logic                          o_bar_valid,
    output logic [ohlcv_pkg::SYM_W-1:0]   o_bar_symbol,
    output logic [ohlcv_pkg::TIME_W-1:0]  o_bar_start,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_open_price,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_high_price,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_low_price,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_close_price,
    output logic [ohlcv_pkg::VOL_W-1:0]   o_bar_volume,
    output logic                          o_last_of_run
);
    import ohlcv_pkg::*;

    t_slot mem [NUM_SYMBOLS];

    logic [NUM_SYMBOLS-1:0] r_valid, n_valid;
    logic [NUM_SYMBOLS-1:0] r_emit, n_emit;

    logic [PRICE_W-1:0] r_price;
    logic [SIZE_W-1:0]  r_size;
    logic [TIME_W-1:0]  r_time;
    logic [PROD_W-1:0]  r_prod;

    t_slot            r_rd_data;
    logic [IDX_W-1:0] r_rd_addr;

    t_slot            r_buf, n_buf;
    logic [SYM_W-1:0] r_buf_sym, n_buf_sym;
    logic             r_buf_v, n_buf_v;

    logic             r_out_v, n_out_v;
    t_slot            r_out, n_out;
    logic [SYM_W-1:0] r_out_sym, n_out_sym;
    logic             r_out_last, n_out_last;

    t_slot              cur, upd;
    logic               cur_emit;
    logic [PROD_W-DIV15_SHIFT-1:0] quot;
    logic [TIME_W:0]    period_ext;
    logic [TIME_W-1:0]  period;
    logic               pending, restart, closed;
    logic [VOL_W:0]     vol_sum;
    logic               wr_en;

    // Slots never written since reset read as all zero.
    always_comb begin
        cur      = r_valid[r_rd_addr] ? r_rd_data : '0;
        cur_emit = r_emit[r_rd_addr];
    end

    assign quot       = r_prod[PROD_W-1:DIV15_SHIFT];
    assign period_ext = {quot, 6'b0} - {4'b0, quot, 2'b0};
    assign period     = period_ext[TIME_W-1:0];

    assign pending = (cur.start != '0) && !cur_emit && (cur.close != '0);
    assign restart = cur_emit || (cur.start != period);
    assign closed  = pending &&
                     ({1'b0, r_time} >= ({1'b0, cur.start} + (TIME_W+1)'(BAR_PERIOD)));
    assign vol_sum = {1'b0, cur.volume} + (VOL_W+1)'(r_size);
    assign wr_en   = i_cmd.trade_upd;

    always_comb begin
        upd = cur;
        if (restart) begin
            upd.start  = period;
            upd.open   = r_price;
            upd.high   = r_price;
            upd.low    = r_price;
            upd.volume = VOL_W'(r_size);
        end else begin
            if (r_price > cur.high) upd.high = r_price;
            if (r_price < cur.low)  upd.low  = r_price;
            upd.volume = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
        end
        upd.close = r_price;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.rd_addr];
            r_rd_addr <= i_cmd.rd_addr;
        end
        if (wr_en) begin
            mem[r_rd_addr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_price <= i_price;
            r_size  <= i_trade_size;
            r_time  <= i_time_sec;
            r_prod  <= PROD_W'(i_time_sec[TIME_W-1:2]) * PROD_W'(DIV15_MUL);
        end
    end

    always_comb begin
        n_valid    = r_valid;
        n_emit     = r_emit;
        n_buf      = r_buf;
        n_buf_sym  = r_buf_sym;
        n_buf_v    = r_buf_v;
        n_out_v    = 1'b0;
        n_out      = r_out;
        n_out_sym  = r_out_sym;
        n_out_last = r_out_last;
        if (i_cmd.trade_upd) begin
            n_valid[r_rd_addr] = 1'b1;
            n_emit[r_rd_addr]  = 1'b0;
            if (restart && pending) begin
                n_out_v    = 1'b1;
                n_out      = cur;
                n_out_sym  = SYM_W'(r_rd_addr);
                n_out_last = 1'b1;
            end
        end
        if (i_cmd.tick_eval && closed) begin
            // Hold each closed bar one step so the final one can be flagged.
            n_emit[r_rd_addr] = 1'b1;
            if (r_buf_v) begin
                n_out_v    = 1'b1;
                n_out      = r_buf;
                n_out_sym  = r_buf_sym;
                n_out_last = 1'b0;
            end
            n_buf     = cur;
            n_buf_sym = SYM_W'(r_rd_addr);
            n_buf_v   = 1'b1;
        end
        if (i_cmd.tick_flush && r_buf_v) begin
            n_out_v    = 1'b1;
            n_out      = r_buf;
            n_out_sym  = r_buf_sym;
            n_out_last = 1'b1;
            n_buf_v    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_emit  <= '0;
            r_buf_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_emit  <= n_emit;
            r_buf_v <= n_buf_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_buf_sym  <= n_buf_sym;
        r_out      <= n_out;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    assign o_bar_valid   = r_out_v;
    assign o_bar_symbol  = r_out_sym;
    assign o_bar_start   = r_out.start;
    assign o_open_price  = r_out.open;
    assign o_high_price  = r_out.high;
    assign o_low_price   = r_out.low;
    assign o_close_price = r_out.close;
    assign o_bar_volume  = r_out.volume;
    assign o_last_of_run = r_out_last;

endmodule

// ===== rtl/ohlcv_bar_aggregator.sv =====
// Top level of the one-minute OHLCV bar aggregator.
`timescale 1ns / 1ps
// Trade beat: the symbol's slot is read at accept, then updated and written back while busy;
// a finished bar leaves on o_bar_valid in the cycle after the update.
// Tick beat: a walk of the slot table, one slot per cycle, then a drain and a flush step.
// Synchronous active-low reset clears the valid and emitted flags; the table reads as empty.
// Results are strobed for one cycle each; the receiver cannot stall them.
module ohlcv_bar_aggregator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [ohlcv_pkg::SYM_W-1:0]   i_symbol,
    input  logic [ohlcv_pkg::PRICE_W-1:0] i_price,
    input  logic [ohlcv_pkg::SIZE_W-1:0]  i_trade_size,
    input  logic [ohlcv_pkg::TIME_W-1:0]  i_time_sec,
    output logic                          o_bar_valid,
    output logic [ohlcv_pkg::SYM_W-1:0]   o_bar_symbol,
    output logic [ohlcv_pkg::TIME_W-1:0]  o_bar_start,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_open_price,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_high_price,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_low_price,
    output logic [ohlcv_pkg::PRICE_W-1:0] o_close_price,
    output logic [ohlcv_pkg::VOL_W-1:0]   o_bar_volume,
    output logic                          o_last_of_run
);
    import ohlcv_pkg::*;

    // The controller sequences table reads and tells the datapath what to do with
    // each read slot. A trade reads its slot at the accept edge, then updates it;
    // a trade landing in a new period first sends out the pending bar, and one on a bar
    // already emitted restarts it. A tick reads slots in index order, one per cycle;
    // the datapath tests each one in the following cycle against the tick time.
    t_cmd cmd;

    ohlcv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_symbol (i_symbol),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // The datapath holds the slot table and the result registers. During a tick
    // each closed bar is held for one step, so the last bar of the walk can carry
    // the last-of-run flag when the walk finishes.
    ohlcv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_price       (i_price),
        .i_trade_size  (i_trade_size),
        .i_time_sec    (i_time_sec),
        .o_bar_valid   (o_bar_valid),
        .o_bar_symbol  (o_bar_symbol),
        .o_bar_start   (o_bar_start),
        .o_open_price  (o_open_price),
        .o_high_price  (o_high_price),
        .o_low_price   (o_low_price),
        .o_close_price (o_close_price),
        .o_bar_volume  (o_bar_volume),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== tb/ohlcv_bar_checker.sv =====
// Stimulus codes and the scoreboard that predicts and checks finished OHLCV bars.
`timescale 1ns / 1ps

package ohlcv_tb_pkg;

    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

endpackage

module ohlcv_bar_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_kind,
    input  logic [ohlcv_pkg::SYM_W-1:0]   i_symbol,
    input  logic [ohlcv_pkg::PRICE_W-1:0] i_price,
    input  logic [ohlcv_pkg::SIZE_W-1:0]  i_trade_size,
    input  logic [ohlcv_pkg::TIME_W-1:0]  i_time_sec,
    input  logic                          i_bar_valid,
    input  logic [ohlcv_pkg::SYM_W-1:0]   i_bar_symbol,
    input  logic [ohlcv_pkg::TIME_W-1:0]  i_bar_start,
    input  logic [ohlcv_pkg::PRICE_W-1:0] i_open_price,
    input  logic [ohlcv_pkg::PRICE_W-1:0] i_high_price,
    input  logic [ohlcv_pkg::PRICE_W-1:0] i_low_price,
    input  logic [ohlcv_pkg::PRICE_W-1:0] i_close_price,
    input  logic [ohlcv_pkg::VOL_W-1:0]   i_bar_volume,
    input  logic                          i_last_of_run,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ohlcv_pkg::*;
    import ohlcv_tb_pkg::*;

    localparam int              SUM_W   = VOL_W + 1;
    localparam logic [VOL_W-1:0] VOL_SAT = '1;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol;
        logic [TIME_W-1:0]  period_start;
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
        logic [VOL_W-1:0]   volume;
        logic               last_of_run;
    } t_bar;

    // Shadow copy of the slot table.
    logic [TIME_W-1:0]  shadow_start  [NUM_SYMBOLS];
    logic               shadow_sent   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] shadow_open   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] shadow_high   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] shadow_low    [NUM_SYMBOLS];
    logic [PRICE_W-1:0] shadow_close  [NUM_SYMBOLS];
    logic [VOL_W-1:0]   shadow_volume [NUM_SYMBOLS];

    t_bar bars_due[$];
    t_bar bar_seen;
    t_bar bar_want;
    int   due_before;
    int   mismatch_total = 0;
    int   due_total      = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = due_total;

    // A bar is waiting to go out when it has a period, was not sent and has a close.
    function automatic logic bar_waiting(int s);
        return shadow_start[s] != '0 && !shadow_sent[s] && shadow_close[s] != '0;
    endfunction

    function automatic t_bar bar_of_slot(int s);
        t_bar b;
        b.symbol       = SYM_W'(s);
        b.period_start = shadow_start[s];
        b.open_price   = shadow_open[s];
        b.high_price   = shadow_high[s];
        b.low_price    = shadow_low[s];
        b.close_price  = shadow_close[s];
        b.volume       = shadow_volume[s];
        b.last_of_run  = 1'b0;
        return b;
    endfunction

    task automatic fold_trade(input logic [SYM_W-1:0] sym, input logic [PRICE_W-1:0] price,
                              input logic [SIZE_W-1:0] qty, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] period;
        logic [SUM_W-1:0]  vol_sum;
        int                s;
        s      = int'(sym);
        period = now - (now % TIME_W'(BAR_PERIOD));
        // A new period, or any trade after the bar went out, closes the old bar.
        if (shadow_sent[s] || shadow_start[s] != period) begin
            if (bar_waiting(s)) begin
                bars_due.insert(bars_due.size(), bar_of_slot(s));
            end
            shadow_start[s]  = period;
            shadow_sent[s]   = 1'b0;
            shadow_open[s]   = price;
            shadow_high[s]   = price;
            shadow_low[s]    = price;
            shadow_close[s]  = price;
            shadow_volume[s] = '0;
        end
        if (price > shadow_high[s]) begin
            shadow_high[s] = price;
        end
        if (price < shadow_low[s]) begin
            shadow_low[s] = price;
        end
        shadow_close[s] = price;
        vol_sum = {1'b0, shadow_volume[s]} + SUM_W'(qty);
        shadow_volume[s] = (vol_sum > {1'b0, VOL_SAT}) ? VOL_SAT : vol_sum[VOL_W-1:0];
    endtask

    task automatic flush_closed_bars(input logic [TIME_W-1:0] now);
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
            if (bar_waiting(s) &&
                {1'b0, now} >= {1'b0, shadow_start[s]} + (TIME_W + 1)'(BAR_PERIOD)) begin
                bars_due.insert(bars_due.size(), bar_of_slot(s));
                shadow_sent[s] = 1'b1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SYMBOLS; s++) begin
                shadow_start[s]  = '0;
                shadow_sent[s]   = 1'b0;
                shadow_open[s]   = '0;
                shadow_high[s]   = '0;
                shadow_low[s]    = '0;
                shadow_close[s]  = '0;
                shadow_volume[s] = '0;
            end
            bars_due.delete();
        end else begin
            // Check the result first so a beat accepted on this edge cannot claim it.
            if (i_bar_valid) begin
                bar_seen = '{i_bar_symbol, i_bar_start, i_open_price, i_high_price,
                             i_low_price, i_close_price, i_bar_volume, i_last_of_run};
                if (bars_due.size() == 0) begin
                    $display("%0t: unexpected bar, expected none, actual symbol %0d start %0h",
                             $time, i_bar_symbol, i_bar_start);
                    mismatch_total++;
                end else begin
                    bar_want = bars_due.pop_front();
                    check_field("bar_symbol", 64'(bar_want.symbol), 64'(bar_seen.symbol));
                    check_field("bar_start", 64'(bar_want.period_start),
                                64'(bar_seen.period_start));
                    check_field("open_price", 64'(bar_want.open_price),
                                64'(bar_seen.open_price));
                    check_field("high_price", 64'(bar_want.high_price),
                                64'(bar_seen.high_price));
                    check_field("low_price", 64'(bar_want.low_price),
                                64'(bar_seen.low_price));
                    check_field("close_price", 64'(bar_want.close_price),
                                64'(bar_seen.close_price));
                    check_field("bar_volume", 64'(bar_want.volume), 64'(bar_seen.volume));
                    check_field("last_of_run", 64'(bar_want.last_of_run),
                                64'(bar_seen.last_of_run));
                end
            end
            if (i_start && !i_busy) begin
                due_before = bars_due.size();
                if (i_kind == KIND_TRADE) begin
                    fold_trade(i_symbol, i_price, i_trade_size, i_time_sec);
                end else begin
                    flush_closed_bars(i_time_sec);
                end
                // The final bar this beat produced carries the last-of-run flag.
                if (bars_due.size() > due_before) begin
                    bar_want = bars_due[bars_due.size() - 1];
                    bar_want.last_of_run = 1'b1;
                    bars_due[bars_due.size() - 1] = bar_want;
                end
            end
        end
        due_total = bars_due.size();
    end

endmodule

// ===== tb/ohlcv_bar_aggregator_test.sv =====
// Top of the OHLCV bar aggregator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ohlcv_bar_aggregator_test;
    import ohlcv_pkg::*;
    import ohlcv_tb_pkg::*;

    // Longest legal stretch without an accepted beat is a tick walk plus a sender gap,
    // or the settling pause at the end; the watchdog limit sits well above both.
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BEATS = 100;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               i_kind       = KIND_TRADE;
    logic [SYM_W-1:0]   i_symbol     = '0;
    logic [PRICE_W-1:0] i_price      = '0;
    logic [SIZE_W-1:0]  i_trade_size = '0;
    logic [TIME_W-1:0]  i_time_sec   = '0;
    logic               o_bar_valid;
    logic [SYM_W-1:0]   o_bar_symbol;
    logic [TIME_W-1:0]  o_bar_start;
    logic [PRICE_W-1:0] o_open_price;
    logic [PRICE_W-1:0] o_high_price;
    logic [PRICE_W-1:0] o_low_price;
    logic [PRICE_W-1:0] o_close_price;
    logic [VOL_W-1:0]   o_bar_volume;
    logic               o_last_of_run;

    int fail_count;
    int bars_pending;
    int idle_cycles = 0;
    bit idle_on     = 1'b1;

    always begin
        #5 i_clk = ~i_clk;
    end

    ohlcv_bar_aggregator u_top (.*);

    ohlcv_bar_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_symbol      (i_symbol),
        .i_price       (i_price),
        .i_trade_size  (i_trade_size),
        .i_time_sec    (i_time_sec),
        .i_bar_valid   (o_bar_valid),
        .i_bar_symbol  (o_bar_symbol),
        .i_bar_start   (o_bar_start),
        .i_open_price  (o_open_price),
        .i_high_price  (o_high_price),
        .i_low_price   (o_low_price),
        .i_close_price (o_close_price),
        .i_bar_volume  (o_bar_volume),
        .i_last_of_run (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (bars_pending)
    );

    // Watchdog: any accepted input beat or bar beat restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_bar_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ohlcv_bar_aggregator_test: FAIL");
            $finish;
        end
    end

    // Presents one beat and returns at the edge that accepts it. It is always entered at
    // the accepting edge of the previous beat, so start is either lowered for a gap or
    // simply kept high with new fields; it is never lowered and raised in one step.
    task automatic send_beat(input logic kind, input logic [SYM_W-1:0] sym,
                             input logic [PRICE_W-1:0] price, input logic [SIZE_W-1:0] qty,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= kind;
        i_symbol     <= sym;
        i_price      <= price;
        i_trade_size <= qty;
        i_time_sec   <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_trade(input logic [SYM_W-1:0] sym, input logic [PRICE_W-1:0] price,
                              input logic [SIZE_W-1:0] qty, input logic [TIME_W-1:0] now);
        send_beat(KIND_TRADE, sym, price, qty, now);
    endtask

    // Symbol, price and size are don't-care on a tick, so they carry random junk.
    task automatic send_tick(input logic [TIME_W-1:0] now);
        send_beat(KIND_TICK, SYM_W'($urandom()), $urandom(), $urandom(), now);
    endtask

    // Holds the sender off until the checker has seen every bar it expects.
    // The count is read on the falling edge, away from the checker's update.
    task automatic wait_for_bars();
        start <= 1'b0;
        do @(negedge i_clk); while (bars_pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        logic [TIME_W-1:0]  now_sec;
        logic [PRICE_W-1:0] price;
        logic [SIZE_W-1:0]  qty;
        logic [SYM_W-1:0]   sym;
        logic [PRICE_W-1:0] mid_price [NUM_SYMBOLS];
        int                 roll;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A fresh slot in period zero is updated in place and never
        // emitted; moving it to a real period must not emit anything either.
        send_trade(5'd0, 32'd100, 32'd5, 32'd30);
        send_trade(5'd0, 32'd50, 32'd7, 32'd59);
        send_trade(5'd0, 32'd80, 32'd1, 32'd60);
        // Price and size extremes in one bar.
        send_trade(5'd1, 32'd1, 32'd0, 32'd120);
        send_trade(5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd130);
        send_trade(5'd1, 32'd12345, 32'd3, 32'd179);
        // Time going backwards closes the bar and restarts it in the earlier period.
        send_trade(5'd1, 32'd999, 32'd4, 32'd100);
        // A bar that closes on a zero price is not pending and emits nothing on restart.
        send_trade(5'd2, 32'd0, 32'd9, 32'd200);
        send_trade(5'd2, 32'd5, 32'd2, 32'd300);
        // Last period of the time range: start plus 60 no longer fits in 32 bits.
        send_trade(5'd31, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
        send_tick(32'd1000);
        // A late trade on an emitted bar reopens the same period; the next tick resends it.
        send_trade(5'd1, 32'd4242, 32'd2, 32'd100);
        send_tick(32'd1000);
        send_tick(32'd1000);
        send_tick(32'hFFFF_FFFF);
        send_trade(5'd31, 32'h7FFF_FFFF, 32'd6, 32'hFFFF_FFFF);
        send_trade(5'd31, 32'd3, 32'd1, 32'd0);
        send_trade(5'd5, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_trade(5'd10, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
        send_tick(32'hFFFF_FFFF);

        // Random part: mostly trades on a few busy symbols with time moving forward,
        // closing bars by period change and by ticks, with some backward jumps and
        // fully random beats mixed in.
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
            mid_price[s] = $urandom_range(1000, 2_000_000);
        end
        now_sec = $urandom_range(100_000, 2_000_000_000);
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // Every third stretch of twenty beats runs without sender gaps.
            idle_on = ((n / 20) % 3) != 2;
            if (n == RANDOM_BEATS / 2) begin
                wait_for_bars();
            end
            roll = $urandom_range(0, 99);
            sym  = ($urandom_range(0, 99) < 80) ? SYM_W'($urandom_range(0, 5))
                                                : SYM_W'($urandom());
            if (roll < 12) begin
                now_sec = now_sec + $urandom_range(0, 90);
                send_tick(now_sec);
            end else if (roll < 16) begin
                send_tick($urandom());
            end else if (roll < 20) begin
                send_trade(SYM_W'($urandom()), $urandom(), $urandom(), $urandom());
            end else begin
                price = mid_price[sym] + $urandom_range(0, 400) - 200;
                if ($urandom_range(0, 99) == 0) begin
                    price = '0;
                end
                qty = (roll < 30) ? $urandom() : $urandom_range(0, 5000);
                if (roll < 24) begin
                    send_trade(sym, price, qty, now_sec - $urandom_range(1, 200));
                end else begin
                    now_sec = now_sec + $urandom_range(0, 12);
                    send_trade(sym, price, qty, now_sec);
                end
            end
        end

        // Drain, then give a full tick walk's worth of cycles for any stray bar to show.
        wait_for_bars();
        repeat (NUM_SYMBOLS + 8) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && bars_pending == 0) begin
            $display("ohlcv_bar_aggregator_test: PASS");
        end else begin
            $display("ohlcv_bar_aggregator_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ohlcv_pkg.sv
rtl/ohlcv_ctrl.sv
rtl/ohlcv_dp.sv
rtl/ohlcv_bar_aggregator.sv
tb/ohlcv_bar_checker.sv
tb/ohlcv_bar_aggregator_test.sv
